/* rtl/flat_key_value_stream_parser_macros.svh */
// Assertion macros shared by the parser RTL
`ifndef FLAT_KEY_VALUE_STREAM_PARSER_MACROS_SVH
`define FLAT_KEY_VALUE_STREAM_PARSER_MACROS_SVH

// same-cycle implication, checked out of reset
`define FKVP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fkvp assertion failed");

// next-cycle implication, checked out of reset
`define FKVP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fkvp assertion failed");

`endif

/* rtl/fkvp_pkg.sv */
// Package: codes, characters and helpers of the key/value stream parser
`default_nettype none
package fkvp_pkg;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COMMA  = 8'h2C;

  localparam logic [1:0] FLOW_IDLE  = 2'd0;
  localparam logic [1:0] FLOW_KEY   = 2'd1;
  localparam logic [1:0] FLOW_VALUE = 2'd2;
  localparam logic [1:0] FLOW_FAULT = 2'd3;

  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_VALID   = 3'd1;
  localparam logic [2:0] ERR_PARSE   = 3'd2;
  localparam logic [2:0] ERR_UNKNOWN = 3'd3;
  localparam logic [2:0] ERR_TIMEOUT = 3'd4;

  localparam logic [1:0] ACT_BYTE = 2'd0;
  localparam logic [1:0] ACT_TICK = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;

  localparam logic [2:0] SLOT_NONE   = 3'd7;
  localparam int unsigned CFG_KEYS   = 6;
  localparam logic [2:0] CFG_TIMEOUT = 3'd6;
  localparam logic [16:0] TICK_MAX   = 17'h1FFFF;

  // configured key cut to nchars bytes and at its first zero byte
  function automatic logic [63:0] key_text(input logic [63:0] w, input int unsigned nchars);
    logic [63:0] r;
    logic stop;
    r = '0;
    stop = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (!stop && (i < nchars) && (w[8*i +: 8] != 8'h00)) begin
        r[8*i +: 8] = w[8*i +: 8];
      end else begin
        stop = 1'b1;
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/fkvp_if.sv */
// Valid/ready channel interfaces for parser input and result beats
`default_nettype none
interface fkvp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] byte_in;
  logic [2:0] read_key;
  logic [3:0] read_pos;
  modport source (output valid, action, byte_in, read_key, read_pos, input ready);
  modport sink (input valid, action, byte_in, read_key, read_pos, output ready);
endinterface

interface fkvp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] parse_state;
  logic [2:0] error_code;
  logic       pair_done;
  logic       key_valid;
  logic [2:0] key_index;
  logic       value_changed;
  logic       message_done;
  logic [7:0] read_char;
  modport source (output valid, parse_state, error_code, pair_done, key_valid, key_index,
                  value_changed, message_done, read_char, input ready);
  modport sink (input valid, parse_state, error_code, pair_done, key_valid, key_index,
                value_changed, message_done, read_char, output ready);
endinterface
`default_nettype wire

/* rtl/fkvp_ram.sv */
// Generic single-write, single-read RAM with registered read data
`default_nettype none
module fkvp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* rtl/flat_key_value_stream_parser.sv */
// Flat {key:value,...} byte-stream parser: sequencer, key match and value store
// One beat per item. Ticks and ordinary bytes go from S_IDLE straight to S_DONE;
// reads of stored characters pass through S_RDWAIT for the store's registered
// read data first. A ':' scans the collected key through the receive buffer's
// read port and then compares it with one configured key per cycle. A ',' or
// '}' ending a pair with a known key streams the value through one buffer
// read, one store read and one store write per cycle. The input is not
// ready while an item is being worked on; a finished result sits in the
// output register while the next item is taken. No clearing pass after reset.
`default_nettype none
`include "flat_key_value_stream_parser_macros.svh"
module flat_key_value_stream_parser
  import fkvp_pkg::*;
#(
  parameter int NUM_KEYS   = 6,
  parameter int RX_BUF_LEN = 32,
  parameter int VALUE_LEN  = 16,
  parameter int KEY_CHARS  = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  fkvp_in_if.sink          in_ch,
  fkvp_out_if.source       out_ch,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_idx,
  input  wire logic [63:0] cfg_data
);
  localparam int BUF_CAP = RX_BUF_LEN - 1;
  localparam int CW      = $clog2(RX_BUF_LEN);
  localparam int BAW     = (BUF_CAP > 1) ? $clog2(BUF_CAP) : 1;
  localparam int ST_DEPTH = NUM_KEYS * VALUE_LEN;
  localparam int SAW     = (ST_DEPTH > 1) ? $clog2(ST_DEPTH) : 1;
  localparam int VLW     = $clog2(VALUE_LEN);
  localparam int SW      = $clog2(RX_BUF_LEN + 65);

  typedef enum logic [2:0] {
    S_IDLE, S_KSCAN, S_KCMP, S_VSCAN, S_RDWAIT, S_DONE
  } state_t;

  state_t           state_r;
  logic [1:0]       flow_r;
  logic [2:0]       err_r;
  logic [CW-1:0]    cnt_r;
  logic [2:0]       slot_r;
  logic [63:0]      keych_r;
  logic [16:0]      elapsed_r;
  logic [15:0]      tmo_r;
  logic [63:0]      keyw_r [CFG_KEYS];
  logic [VLW-1:0]   vlen_r [NUM_KEYS];
  logic [SW-1:0]    j_r;
  logic [SW-1:0]    pj_r;
  logic             pend_r;
  logic [2:0]       k_r;
  logic             pair_r, kvalid_r, changed_r, msg_r;
  logic [7:0]       rchar_r;

  logic             out_v_r;
  logic [1:0]       out_ps_r;
  logic [2:0]       out_ec_r;
  logic             out_pair_r, out_kv_r, out_chg_r, out_msg_r;
  logic [2:0]       out_ki_r;
  logic [7:0]       out_rc_r;

  logic             accept;
  logic             is_push;
  logic             buf_we;
  logic [7:0]       bdata;
  logic [7:0]       sdata;
  logic             st_we;
  logic [SAW-1:0]   st_waddr, st_raddr;
  logic [SAW-1:0]   st_base;
  logic             rd_ok;
  logic             ch_ok;
  logic [63:0]      ktext;
  logic [16:0]      tick_inc;

  assign accept  = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign is_push = (in_ch.action == ACT_BYTE) && (in_ch.byte_in != CH_QUOTE)
                && (((flow_r == FLOW_KEY) && (in_ch.byte_in != CH_COLON))
                 || ((flow_r == FLOW_VALUE) && (in_ch.byte_in != CH_COMMA)
                     && (in_ch.byte_in != CH_RBRACE)));
  assign buf_we  = accept && is_push && (32'(cnt_r) < BUF_CAP);

  assign st_base = SAW'(32'(slot_r) * VALUE_LEN);
  assign st_waddr = SAW'(st_base + SAW'(pj_r));
  assign st_raddr = (state_r == S_IDLE)
                  ? SAW'(32'(in_ch.read_key) * VALUE_LEN + 32'(in_ch.read_pos))
                  : SAW'(st_base + SAW'(j_r));
  // character seen at pj_r is part of the text
  assign ch_ok   = (32'(pj_r) < 32'(cnt_r)) && (bdata != 8'h00);
  assign st_we   = (state_r == S_VSCAN) && pend_r && ch_ok && (32'(pj_r) < VALUE_LEN - 1);
  assign rd_ok   = (32'(in_ch.read_key) < NUM_KEYS)
                && (32'(in_ch.read_pos) < VALUE_LEN)
                && (32'(in_ch.read_pos) < 32'(vlen_r[in_ch.read_key]));
  assign ktext   = key_text(keyw_r[k_r], KEY_CHARS);
  assign tick_inc = (elapsed_r < TICK_MAX) ? elapsed_r + 17'd1 : elapsed_r;

  fkvp_ram #(.WIDTH(8), .DEPTH(BUF_CAP)) u_buf (
    .clk   (clk),
    .we    (buf_we),
    .waddr (cnt_r[BAW-1:0]),
    .wdata (in_ch.byte_in),
    .raddr (j_r[BAW-1:0]),
    .rdata (bdata)
  );

  fkvp_ram #(.WIDTH(8), .DEPTH(ST_DEPTH)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (bdata),
    .raddr (st_raddr),
    .rdata (sdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      flow_r    <= FLOW_IDLE;
      err_r     <= ERR_NONE;
      cnt_r     <= '0;
      slot_r    <= SLOT_NONE;
      elapsed_r <= '0;
      tmo_r     <= 16'd1000;
      pend_r    <= 1'b0;
      out_v_r   <= 1'b0;
      for (int i = 0; i < CFG_KEYS; i++) keyw_r[i] <= '0;
      for (int i = 0; i < NUM_KEYS; i++) vlen_r[i] <= '0;
    end else begin
      if (cfg_we) begin
        if (32'(cfg_idx) < CFG_KEYS) begin
          keyw_r[cfg_idx] <= cfg_data;
        end else if (cfg_idx == CFG_TIMEOUT) begin
          tmo_r <= cfg_data[15:0];
        end
      end
      // in S_DONE the output register is reloaded instead
      if (out_v_r && out_ch.ready && (state_r != S_DONE)) begin
        out_v_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (accept) begin
            pair_r    <= 1'b0;
            kvalid_r  <= 1'b0;
            changed_r <= 1'b0;
            msg_r     <= 1'b0;
            rchar_r   <= 8'h00;
            j_r       <= '0;
            pend_r    <= 1'b0;
            state_r   <= S_DONE;
            case (in_ch.action)
              ACT_BYTE: begin
                if (is_push) begin
                  if (32'(cnt_r) < BUF_CAP) begin
                    cnt_r <= cnt_r + 1'b1;
                  end else begin
                    flow_r <= FLOW_FAULT;
                    err_r  <= ERR_PARSE;
                  end
                end else begin
                  case (flow_r)
                    FLOW_IDLE: begin
                      if (in_ch.byte_in == CH_LBRACE) begin
                        flow_r <= FLOW_KEY;
                        cnt_r  <= '0;
                        slot_r <= SLOT_NONE;
                      end
                    end
                    FLOW_KEY: begin
                      if (in_ch.byte_in == CH_COLON) begin
                        flow_r  <= FLOW_VALUE;
                        keych_r <= '0;
                        state_r <= S_KSCAN;
                      end
                    end
                    FLOW_VALUE: begin
                      if (in_ch.byte_in != CH_QUOTE) begin
                        pair_r <= 1'b1;
                        if (in_ch.byte_in == CH_COMMA) begin
                          flow_r <= FLOW_KEY;
                        end else begin
                          flow_r    <= FLOW_IDLE;
                          err_r     <= ERR_VALID;
                          elapsed_r <= '0;
                          msg_r     <= 1'b1;
                        end
                        if (32'(slot_r) < NUM_KEYS) begin
                          kvalid_r <= 1'b1;
                          state_r  <= S_VSCAN;
                        end else begin
                          cnt_r <= '0;
                        end
                      end
                    end
                    default: begin
                      flow_r <= FLOW_IDLE;
                      err_r  <= ERR_UNKNOWN;
                    end
                  endcase
                end
              end
              ACT_TICK: begin
                if (err_r == ERR_VALID) begin
                  elapsed_r <= tick_inc;
                  if (tick_inc > {1'b0, tmo_r}) err_r <= ERR_TIMEOUT;
                end
              end
              ACT_READ: begin
                if (rd_ok) state_r <= S_RDWAIT;
              end
              default: begin
              end
            endcase
          end
        end

        S_KSCAN: begin
          j_r    <= j_r + 1'b1;
          pend_r <= 1'b1;
          pj_r   <= j_r;
          if (pend_r) begin
            if (!ch_ok) begin
              pend_r <= 1'b0;
              if (pj_r == '0) begin
                slot_r  <= SLOT_NONE;
                cnt_r   <= '0;
                state_r <= S_DONE;
              end else begin
                k_r     <= '0;
                state_r <= S_KCMP;
              end
            end else if (32'(pj_r) == KEY_CHARS) begin
              // key longer than allowed matches nothing
              pend_r  <= 1'b0;
              slot_r  <= SLOT_NONE;
              cnt_r   <= '0;
              state_r <= S_DONE;
            end else begin
              keych_r[{pj_r[2:0], 3'b000} +: 8] <= bdata;
            end
          end
        end

        S_KCMP: begin
          if ((ktext != '0) && (ktext == keych_r)) begin
            slot_r  <= k_r;
            cnt_r   <= '0;
            state_r <= S_DONE;
          end else if (32'(k_r) == NUM_KEYS - 1) begin
            slot_r  <= SLOT_NONE;
            cnt_r   <= '0;
            state_r <= S_DONE;
          end else begin
            k_r <= k_r + 1'b1;
          end
        end

        S_VSCAN: begin
          j_r    <= j_r + 1'b1;
          pend_r <= 1'b1;
          pj_r   <= j_r;
          if (pend_r) begin
            if (!ch_ok) begin
              // text ends here: length is pj_r, at most VALUE_LEN-1
              if (32'(pj_r) != 32'(vlen_r[slot_r])) changed_r <= 1'b1;
              vlen_r[slot_r] <= pj_r[VLW-1:0];
              pend_r  <= 1'b0;
              cnt_r   <= '0;
              state_r <= S_DONE;
            end else if (32'(pj_r) == VALUE_LEN - 1) begin
              // longer than the store holds: truncated, always changed
              changed_r      <= 1'b1;
              vlen_r[slot_r] <= VLW'(VALUE_LEN - 1);
              pend_r  <= 1'b0;
              cnt_r   <= '0;
              state_r <= S_DONE;
            end else if ((32'(pj_r) >= 32'(vlen_r[slot_r])) || (sdata != bdata)) begin
              changed_r <= 1'b1;
            end
          end
        end

        S_RDWAIT: begin
          rchar_r <= sdata;
          state_r <= S_DONE;
        end

        S_DONE: begin
          if (!out_v_r || out_ch.ready) begin
            out_v_r    <= 1'b1;
            out_ps_r   <= flow_r;
            out_ec_r   <= err_r;
            out_pair_r <= pair_r;
            out_kv_r   <= kvalid_r;
            out_ki_r   <= kvalid_r ? slot_r : 3'd0;
            out_chg_r  <= kvalid_r & changed_r;
            out_msg_r  <= msg_r;
            out_rc_r   <= rchar_r;
            state_r    <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.parse_state   = out_ps_r;
  assign out_ch.error_code    = out_ec_r;
  assign out_ch.pair_done     = out_pair_r;
  assign out_ch.key_valid     = out_kv_r;
  assign out_ch.key_index     = out_ki_r;
  assign out_ch.value_changed = out_chg_r;
  assign out_ch.message_done  = out_msg_r;
  assign out_ch.read_char     = out_rc_r;

  `FKVP_ASSERT_NEXT(a_busy_after_accept, accept, state_r != S_IDLE)
  `FKVP_ASSERT_NOW(a_cnt_cap, 1'b1, 32'(cnt_r) <= BUF_CAP)
  `FKVP_ASSERT_NOW(a_vscan_bound, (state_r == S_VSCAN) && pend_r, 32'(pj_r) <= VALUE_LEN - 1)
  `FKVP_ASSERT_NOW(a_kscan_bound, (state_r == S_KSCAN) && pend_r, 32'(pj_r) <= KEY_CHARS)
  `FKVP_ASSERT_NOW(a_key_pair, out_v_r && out_kv_r, out_pair_r && (32'(out_ki_r) < NUM_KEYS))
endmodule
`default_nettype wire
